// ----- design/sit_pkg.sv -----
// Shared definitions for the segment intersection test unit.
// Holds the default coordinate width, the field order in the input word and the
// orientation codes. It depends on nothing else.
package sit_pkg;

    // Default width of one coordinate field.
    localparam int COORD_BITS_DEF = 16;

    // Number of coordinate fields in one input word, and where each one sits.
    localparam int NUM_FIELDS       = 8;
    localparam int FLD_A_START_X    = 0;
    localparam int FLD_A_START_Y    = 1;
    localparam int FLD_A_END_X      = 2;
    localparam int FLD_A_END_Y      = 3;
    localparam int FLD_B_START_X    = 4;
    localparam int FLD_B_START_Y    = 5;
    localparam int FLD_B_END_X      = 6;
    localparam int FLD_B_END_Y      = 7;

    // The result word carries a single bit, padded to one byte.
    localparam int OUT_TDATA_W = 8;

    // Turn direction of a point against a directed line.
    typedef enum logic [1:0] {
        ORIENT_COLLINEAR = 2'd0,
        ORIENT_POS       = 2'd1,
        ORIENT_NEG       = 2'd2
    } orient_t;

endpackage

// ----- design/sit_orient.sv -----
// Orientation of point r against the line from p to q, as a pipelined slice.
// The two cross-product terms are multiplied and registered, then compared.
// Depends on sit_pkg for the orientation codes.
module sit_orient #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    input  logic signed [COORD_BITS-1:0] rx,
    input  logic signed [COORD_BITS-1:0] ry,
    output sit_pkg::orient_t             orient
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] d_qy_py;
    logic signed [DW-1:0] d_rx_qx;
    logic signed [DW-1:0] d_qx_px;
    logic signed [DW-1:0] d_ry_qy;
    logic signed [PW-1:0] lhs_next;
    logic signed [PW-1:0] rhs_next;
    logic signed [PW-1:0] lhs_reg;
    logic signed [PW-1:0] rhs_reg;

    // Differences are one bit wider than the coordinates, so they are exact.
    assign d_qy_py = $signed({qy[COORD_BITS-1], qy}) - $signed({py[COORD_BITS-1], py});
    assign d_rx_qx = $signed({rx[COORD_BITS-1], rx}) - $signed({qx[COORD_BITS-1], qx});
    assign d_qx_px = $signed({qx[COORD_BITS-1], qx}) - $signed({px[COORD_BITS-1], px});
    assign d_ry_qy = $signed({ry[COORD_BITS-1], ry}) - $signed({qy[COORD_BITS-1], qy});

    assign lhs_next = PW'(d_qy_py) * PW'(d_rx_qx);
    assign rhs_next = PW'(d_qx_px) * PW'(d_ry_qy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs_reg <= lhs_next;
            rhs_reg <= rhs_next;
        end
    end

    // The sign of the cross value is the outcome of comparing its two terms.
    always_comb
    begin
        if (lhs_reg > rhs_reg)
        begin
            orient = sit_pkg::ORIENT_POS;
        end
        else if (lhs_reg < rhs_reg)
        begin
            orient = sit_pkg::ORIENT_NEG;
        end
        else
        begin
            orient = sit_pkg::ORIENT_COLLINEAR;
        end
    end

endmodule

// ----- design/segment_intersection_test_unit.sv -----
// Top level of the segment intersection test unit.
// Uses sit_pkg for field positions and orientation codes, and sit_orient for
// the four cross-product orientation slices.
//
// Usage:
//   The slave stream takes one word per segment pair: eight signed coordinates
//   of COORD_BITS bits each, segment A start x/y and end x/y, then segment B
//   start x/y and end x/y. The master stream returns one word per pair whose
//   bit 0 is set when the segments intersect without sharing an endpoint.
//   The datapath is three register stages deep: an input register, the
//   registered cross-product terms, and the result register. An accepted
//   pair moves through them in that order, held while the next one stalls.
//   One pair is accepted every cycle while the master side keeps taking
//   words; the multipliers in the orientation slices set the length of the
//   first stage, the product comparison that of the second. When the
//   receiver stalls, the stages fill one by one and s_axis_tready drops
//   only once all three hold a word; no word is lost or repeated.
//   Reset empties all stages; the block holds no other state.
module segment_intersection_test_unit #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // Fields from bit 0 up: a_start_x, a_start_y, a_end_x, a_end_y,
    // b_start_x, b_start_y, b_end_x, b_end_y, then zero padding.
    input  logic [((8*COORD_BITS+7)/8)*8-1:0]          s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // Fields from bit 0 up: crosses, then zero padding.
    output logic [sit_pkg::OUT_TDATA_W-1:0]            m_axis_tdata
);

    typedef struct packed {
        logic       shared;
        logic [3:0] box;
    } flags_t;

    logic adv_out;
    logic adv_s2;
    logic adv_s1;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic signed [COORD_BITS-1:0] coord_reg [sit_pkg::NUM_FIELDS];
    logic signed [COORD_BITS-1:0] ax0;
    logic signed [COORD_BITS-1:0] ay0;
    logic signed [COORD_BITS-1:0] ax1;
    logic signed [COORD_BITS-1:0] ay1;
    logic signed [COORD_BITS-1:0] bx0;
    logic signed [COORD_BITS-1:0] by0;
    logic signed [COORD_BITS-1:0] bx1;
    logic signed [COORD_BITS-1:0] by1;

    flags_t flags_next;
    flags_t flags_reg;

    sit_pkg::orient_t o1;
    sit_pkg::orient_t o2;
    sit_pkg::orient_t o3;
    sit_pkg::orient_t o4;

    logic crosses_next;
    logic crosses_reg;

    function automatic logic in_box(
        input logic signed [COORD_BITS-1:0] ex,
        input logic signed [COORD_BITS-1:0] ey,
        input logic signed [COORD_BITS-1:0] mx,
        input logic signed [COORD_BITS-1:0] my,
        input logic signed [COORD_BITS-1:0] fx,
        input logic signed [COORD_BITS-1:0] fy
    );
        logic x_ok;
        logic y_ok;
        x_ok = (mx >= ex && mx <= fx) || (mx >= fx && mx <= ex);
        y_ok = (my >= ey && my <= fy) || (my >= fy && my <= ey);
        return x_ok && y_ok;
    endfunction

    // A stage may take a new word when it is empty or its word moves on.
    assign adv_out       = !out_valid_reg || m_axis_tready;
    assign adv_s2        = !s2_valid_reg || adv_out;
    assign adv_s1        = !s1_valid_reg || adv_s2;
    assign s_axis_tready = adv_s1;

    assign s1_valid_next  = adv_s1 ? s_axis_tvalid : s1_valid_reg;
    assign s2_valid_next  = adv_s2 ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = adv_out ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1 && s_axis_tvalid)
        begin
            for (int i = 0; i < sit_pkg::NUM_FIELDS; i++)
            begin
                coord_reg[i] <= s_axis_tdata[i*COORD_BITS +: COORD_BITS];
            end
        end
    end

    assign ax0 = coord_reg[sit_pkg::FLD_A_START_X];
    assign ay0 = coord_reg[sit_pkg::FLD_A_START_Y];
    assign ax1 = coord_reg[sit_pkg::FLD_A_END_X];
    assign ay1 = coord_reg[sit_pkg::FLD_A_END_Y];
    assign bx0 = coord_reg[sit_pkg::FLD_B_START_X];
    assign by0 = coord_reg[sit_pkg::FLD_B_START_Y];
    assign bx1 = coord_reg[sit_pkg::FLD_B_END_X];
    assign by1 = coord_reg[sit_pkg::FLD_B_END_Y];

    // Endpoint coincidence and the four bounding-box tests run beside the
    // multipliers and are registered with the products.
    always_comb
    begin
        flags_next.shared = (ax0 == bx0 && ay0 == by0) || (ax0 == bx1 && ay0 == by1) ||
                            (ax1 == bx0 && ay1 == by0) || (ax1 == bx1 && ay1 == by1);
        flags_next.box[0] = in_box(ax0, ay0, bx0, by0, ax1, ay1);
        flags_next.box[1] = in_box(ax0, ay0, bx1, by1, ax1, ay1);
        flags_next.box[2] = in_box(bx0, by0, ax0, ay0, bx1, by1);
        flags_next.box[3] = in_box(bx0, by0, ax1, ay1, bx1, by1);
    end

    always_ff @(posedge clk)
    begin
        if (adv_s2 && s1_valid_reg)
        begin
            flags_reg <= flags_next;
        end
    end

    sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_1 (
        .clk    (clk),
        .en     (adv_s2 && s1_valid_reg),
        .px     (ax0),
        .py     (ay0),
        .qx     (ax1),
        .qy     (ay1),
        .rx     (bx0),
        .ry     (by0),
        .orient (o1)
    );

    sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_2 (
        .clk    (clk),
        .en     (adv_s2 && s1_valid_reg),
        .px     (ax0),
        .py     (ay0),
        .qx     (ax1),
        .qy     (ay1),
        .rx     (bx1),
        .ry     (by1),
        .orient (o2)
    );

    sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_3 (
        .clk    (clk),
        .en     (adv_s2 && s1_valid_reg),
        .px     (bx0),
        .py     (by0),
        .qx     (bx1),
        .qy     (by1),
        .rx     (ax0),
        .ry     (ay0),
        .orient (o3)
    );

    sit_orient #(.COORD_BITS(COORD_BITS)) u_orient_4 (
        .clk    (clk),
        .en     (adv_s2 && s1_valid_reg),
        .px     (bx0),
        .py     (by0),
        .qx     (bx1),
        .qy     (by1),
        .rx     (ax1),
        .ry     (ay1),
        .orient (o4)
    );

    // A proper crossing, or a collinear endpoint lying inside the other box.
    always_comb
    begin
        crosses_next = !flags_reg.shared &&
                       ((o1 != o2 && o3 != o4) ||
                        (o1 == sit_pkg::ORIENT_COLLINEAR && flags_reg.box[0]) ||
                        (o2 == sit_pkg::ORIENT_COLLINEAR && flags_reg.box[1]) ||
                        (o3 == sit_pkg::ORIENT_COLLINEAR && flags_reg.box[2]) ||
                        (o4 == sit_pkg::ORIENT_COLLINEAR && flags_reg.box[3]));
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && s2_valid_reg)
        begin
            crosses_reg <= crosses_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(sit_pkg::OUT_TDATA_W-1){1'b0}}, crosses_reg};

    // Input is refused whenever every stage holds a word and the output stalls.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input refused or taken against stage occupancy");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> s1_valid_reg)
        else $error("accepted word did not reach the input register");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && adv_out) |=> out_valid_reg)
        else $error("word in the product stage was dropped");

    a_shared_no_cross: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && adv_out && flags_reg.shared) |=> !m_axis_tdata[0])
        else $error("shared endpoint reported as a crossing");

endmodule
